[hdl/dgc_pkg.sv]
// Shared types, codes and a helper function for the DSATUR colourability block.
// No dependencies; dgc_dp, dgc_ctrl and the top level refer to this package.
package dgc_pkg;

    localparam logic [3:0] UNCOLOURED  = 4'hF;
    localparam int         COLOUR_SLOTS = 15;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEST = 1'b1;

    localparam int         ADDR_W            = 3;
    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [2:0] ADDR_COLOUR_COUNT = 3'd4;

    localparam logic [4:0] VERTEX_COUNT_RST = 5'd9;
    localparam logic [3:0] COLOUR_COUNT_RST = 4'd3;

    typedef struct packed {
        logic ld_row;
        logic init;
        logic scan_clr;
        logic scan_step;
        logic choose;
        logic try_colour;
    } dgc_cmd_t;

    typedef struct packed {
        logic depth_ge_total;
        logic scan_last;
        logic best_valid;
        logic colour_found;
        logic depth_zero;
    } dgc_status_t;

    function automatic logic [4:0] popcount16(input logic [15:0] x);
        logic [4:0] c;
        c = 5'd0;
        for (int i = 0; i < 16; i++) begin
            c = c + 5'(x[i]);
        end
        return c;
    endfunction

endpackage

[hdl/dgc_in_if.sv]
// Input channel of the colourability block: valid/ready plus the item fields.
// Depends on nothing.
interface dgc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [15:0] vertex_subset;

    modport source (output valid, action, row_index, row_bits, vertex_subset, input ready);
    modport sink   (input valid, action, row_index, row_bits, vertex_subset, output ready);
endinterface

[hdl/dgc_out_if.sv]
// Result channel of the colourability block: valid/ready plus the flag.
// Depends on nothing.
interface dgc_out_if;
    logic valid;
    logic ready;
    logic colourable;

    modport source (output valid, colourable, input ready);
    modport sink   (input valid, colourable, output ready);
endinterface

[hdl/dgc_dp.sv]
// Datapath: adjacency store, colour array, choice stack, DSATUR scan and colour pick.
// Depends on dgc_pkg; driven by dgc_ctrl through dgc_cmd_t / dgc_status_t.
module dgc_dp #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dgc_pkg::dgc_cmd_t    cmd,
    output dgc_pkg::dgc_status_t status,
    input  logic [3:0]           row_index,
    input  logic [15:0]          row_bits,
    input  logic [15:0]          vertex_subset,
    input  logic [4:0]           vertex_count,
    input  logic [3:0]           colour_count
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [VW-1:0]           stack_mem [MAX_VERTICES];
    logic [3:0]              colour_reg [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] subset_reg;
    logic [DW-1:0]           depth_reg;
    logic [VW-1:0]           idx_reg;
    logic [VW-1:0]           best_v_reg;
    logic [4:0]              top_sat_reg;
    logic [4:0]              top_deg_reg;
    logic                    best_valid_reg;
    logic [VW-1:0]           cur_v_reg;
    logic [3:0]              start_reg;

    logic [4:0]              n_lim;
    logic [MAX_VERTICES-1:0] subset_masked;
    logic [VW-1:0]           rd_v;
    logic [MAX_VERTICES-1:0] rd_row;
    logic [15:0]             forb;
    logic [4:0]              sat;
    logic [4:0]              deg;
    logic [DW-1:0]           depth_m1;
    logic [VW-1:0]           top_v;
    logic [VW-1:0]           cr_addr;
    logic [3:0]              cr;
    logic                    cand;
    logic                    better;
    logic                    found;
    logic [3:0]              pick;

    always_comb
    begin
        n_lim = (vertex_count > 5'(MAX_VERTICES)) ? 5'(MAX_VERTICES) : vertex_count;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            subset_masked[i] = vertex_subset[i] && (5'(i) < n_lim);
        end

        rd_v   = cmd.scan_step ? idx_reg : cur_v_reg;
        rd_row = adj_mem[rd_v];

        // colours already used by neighbours seen through the row of rd_v
        forb = 16'd0;
        for (int w = 0; w < MAX_VERTICES; w++) begin
            if (rd_row[w] && (colour_reg[w] != dgc_pkg::UNCOLOURED)) begin
                forb = forb | (16'd1 << colour_reg[w]);
            end
        end
        sat = dgc_pkg::popcount16(forb);
        deg = dgc_pkg::popcount16(16'(rd_row & subset_reg));

        depth_m1 = depth_reg - DW'(1);
        top_v    = stack_mem[depth_m1[VW-1:0]];
        cr_addr  = cmd.scan_step ? idx_reg : top_v;
        cr       = colour_reg[cr_addr];

        cand   = subset_reg[idx_reg] && (cr == dgc_pkg::UNCOLOURED);
        better = !best_valid_reg || (sat > top_sat_reg)
                 || ((sat == top_sat_reg) && (deg > top_deg_reg));

        // lowest free colour at or above start_reg
        found = 1'b0;
        pick  = 4'd0;
        for (int c = dgc_pkg::COLOUR_SLOTS - 1; c >= 0; c--) begin
            if ((4'(c) >= start_reg) && (4'(c) < colour_count) && !forb[c]) begin
                found = 1'b1;
                pick  = 4'(c);
            end
        end

        status.depth_ge_total = 5'(depth_reg) >= dgc_pkg::popcount16(16'(subset_reg));
        status.scan_last      = idx_reg == VW'(MAX_VERTICES - 1);
        status.best_valid     = best_valid_reg;
        status.colour_found   = found;
        status.depth_zero     = depth_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                colour_reg[i] <= dgc_pkg::UNCOLOURED;
            end
            depth_reg      <= '0;
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
        end else begin
            if (cmd.init) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    colour_reg[i] <= dgc_pkg::UNCOLOURED;
                end
                depth_reg <= '0;
            end
            if (cmd.scan_clr) begin
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (cand && better) begin
                    best_valid_reg <= 1'b1;
                end
                idx_reg <= idx_reg + VW'(1);
            end
            if (cmd.try_colour) begin
                if (found) begin
                    colour_reg[cur_v_reg] <= pick;
                    depth_reg             <= depth_reg + DW'(1);
                end else if (depth_reg != '0) begin
                    // backtrack: uncolour the previous choice
                    colour_reg[top_v] <= dgc_pkg::UNCOLOURED;
                    depth_reg         <= depth_m1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_row && (5'(row_index) < 5'(MAX_VERTICES))) begin
            adj_mem[row_index[VW-1:0]] <= row_bits[MAX_VERTICES-1:0];
        end
        if (cmd.init) begin
            subset_reg <= subset_masked;
        end
        if (cmd.scan_step && cand && better) begin
            best_v_reg  <= idx_reg;
            top_sat_reg <= sat;
            top_deg_reg <= deg;
        end
        if (cmd.choose) begin
            cur_v_reg                     <= best_v_reg;
            start_reg                     <= 4'd0;
            stack_mem[depth_reg[VW-1:0]] <= best_v_reg;
        end
        if (cmd.try_colour && !found && (depth_reg != '0)) begin
            cur_v_reg <= top_v;
            start_reg <= cr + 4'd1;
        end
    end

endmodule

[hdl/dgc_ctrl.sv]
// Controller: sequences load, DSATUR scan, colour trials and backtracking.
// Depends on dgc_pkg; commands dgc_dp and owns the result register.
module dgc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_colourable,
    output dgc_pkg::dgc_cmd_t    cmd,
    input  dgc_pkg::dgc_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SEL,
        S_TRY,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   colourable_reg;
    logic   result_reg;

    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = out_valid_reg;
    assign out_colourable = colourable_reg;

    always_comb
    begin
        cmd.ld_row     = in_ready && in_valid && (in_action == dgc_pkg::ACTION_LOAD);
        cmd.init       = in_ready && in_valid && (in_action == dgc_pkg::ACTION_TEST);
        cmd.scan_clr   = state_reg == S_CHECK;
        cmd.scan_step  = state_reg == S_SCAN;
        cmd.choose     = (state_reg == S_SEL) && status.best_valid;
        cmd.try_colour = state_reg == S_TRY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            colourable_reg <= 1'b0;
            result_reg     <= 1'b0;
        end else begin
            // S_DONE decides the result register on its own
            if (out_valid_reg && out_ready && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.init) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (status.depth_ge_total) begin
                        result_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.scan_last) begin
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    if (!status.best_valid) begin
                        result_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_TRY;
                    end
                end
                S_TRY:
                begin
                    if (status.colour_found) begin
                        state_reg <= S_CHECK;
                    end else if (status.depth_zero) begin
                        result_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold until the result register is free
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg  <= 1'b1;
                        colourable_reg <= result_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/dsatur_graph_colourability.sv]
// Timing: a load is written at its handshake; a test runs S_CHECK, S_SCAN, S_SEL, S_TRY
// per colouring step, S_TRY per backtrack (data dependent); the vertex scan (one vertex
// a cycle) dominates. Throughput: one test at a time; loads are taken every cycle while idle.
// Reset (rst_n, async low): controller idle, colours uncoloured, vertex_count 9,
// colour_count 3; adjacency rows hold no defined value until written.
module dsatur_graph_colourability #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dgc_in_if.sink                       item,
    dgc_out_if.source                    result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dgc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [4:0] vertex_count_reg;
    logic [3:0] colour_count_reg;
    logic       cfg_wr;

    dgc_pkg::dgc_cmd_t    cmd;
    dgc_pkg::dgc_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vertex_count_reg <= dgc_pkg::VERTEX_COUNT_RST;
            colour_count_reg <= dgc_pkg::COLOUR_COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr == dgc_pkg::ADDR_VERTEX_COUNT) begin
                vertex_count_reg <= pwdata[4:0];
            end
            if (paddr == dgc_pkg::ADDR_COLOUR_COUNT) begin
                colour_count_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            dgc_pkg::ADDR_VERTEX_COUNT: prdata = 32'(vertex_count_reg);
            dgc_pkg::ADDR_COLOUR_COUNT: prdata = 32'(colour_count_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    dgc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (item.valid),
        .in_action      (item.action),
        .in_ready       (item.ready),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_colourable (result.colourable),
        .cmd            (cmd),
        .status         (status)
    );

    dgc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .row_index     (item.row_index),
        .row_bits      (item.row_bits),
        .vertex_subset (item.vertex_subset),
        .vertex_count  (vertex_count_reg),
        .colour_count  (colour_count_reg)
    );

endmodule

[hdl/dgc_checker.sv]
// Port-level checks for dsatur_graph_colourability, attached with bind.
// Depends on the top level's ports only.
module dgc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_action,
    input logic out_valid,
    input logic out_ready,
    input logic out_colourable
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_colourable))
        else $error("result changed while stalled");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised right after an input transfer");

    a_busy_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> !in_ready)
        else $error("input taken while a test is running");

endmodule

bind dsatur_graph_colourability dgc_checker u_dgc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .in_action      (item.action),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_colourable (result.colourable)
);
